@@ rtl/chebyshev_series_evaluator_defines.svh @@
// Assertion helpers shared by the evaluator RTL.
`ifndef CHEBYSHEV_SERIES_EVALUATOR_DEFINES_SVH
`define CHEBYSHEV_SERIES_EVALUATOR_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define CSE_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check that cons holds in the cycle after ante.
`define CSE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/cse_pkg.sv @@
`default_nettype none

package cse_pkg;

  localparam int T_W        = 32;  // Q2.30 polynomial value and sample
  localparam int COEF_W     = 32;  // Q8.24 coefficient
  localparam int PROD_W     = 64;  // full product width
  localparam int DIFF_W     = 34;  // rounded 2x*T minus T(k-2)
  localparam int SUM_W      = 36;  // running Q.24 sum, holds 1 + 7 full-scale terms
  localparam int OUT_W      = 48;
  localparam int ORDER_W    = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_SERIES_ORDER = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_1       = 3'd1;

  localparam logic signed [T_W-1:0]   ONE_Q30     = 32'sh4000_0000;
  localparam logic signed [T_W-1:0]   NEG_ONE_Q30 = 32'shC000_0000;
  localparam logic signed [SUM_W-1:0] ONE_Q24     = 36'sh0_0100_0000;

  // Rounding offsets: half LSB at the 29- and 30-bit shifts
  localparam logic signed [PROD_W-1:0] HALF_SH29 = 64'sh0000_0000_1000_0000;
  localparam logic signed [PROD_W-1:0] HALF_SH30 = 64'sh0000_0000_2000_0000;

  typedef struct packed {
    logic signed [T_W-1:0] x_value;
    logic                  last_sample;
  } sample_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] series_value;
    logic                    last_result;
  } result_t;

  // Data handed from one cell to the next
  typedef struct packed {
    logic                    valid;
    logic signed [T_W-1:0]   x;
    logic signed [T_W-1:0]   t_cur;
    logic signed [T_W-1:0]   t_old;
    logic signed [SUM_W-1:0] sum;
    logic                    last;
  } cell_bus_t;

endpackage

`default_nettype wire

@@ rtl/cse_cell.sv @@
`default_nettype none
`include "chebyshev_series_evaluator_defines.svh"

// One term of the series: multiply, then round, add and step the recurrence.
module cse_cell import cse_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  cell_bus_t                up,
  output logic                     up_ready,
  input  logic signed [COEF_W-1:0] coef,
  input  logic                     active,
  output cell_bus_t                dn,
  input  logic                     dn_ready
);

  logic                     a_valid;
  logic signed [T_W-1:0]    a_x;
  logic signed [T_W-1:0]    a_t_cur;
  logic signed [T_W-1:0]    a_t_old;
  logic signed [SUM_W-1:0]  a_sum;
  logic                     a_last;
  logic signed [PROD_W-1:0] a_pt;
  logic signed [PROD_W-1:0] a_pc;

  logic                     b_valid;
  logic signed [T_W-1:0]    b_x;
  logic signed [T_W-1:0]    b_t_cur;
  logic signed [T_W-1:0]    b_t_old;
  logic signed [SUM_W-1:0]  b_sum;
  logic                     b_last;

  logic a_ready;
  logic b_ready;

  logic signed [PROD_W-1:0] pt_round;
  logic signed [PROD_W-1:0] pc_round;
  logic signed [DIFF_W-1:0] diff;
  logic signed [T_W-1:0]    t_next;
  logic signed [SUM_W-1:0]  term;
  logic signed [SUM_W-1:0]  sum_next;

  assign b_ready  = !b_valid || dn_ready;
  assign a_ready  = !a_valid || b_ready;
  assign up_ready = a_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= up.valid;
    end
    if (a_ready && up.valid) begin
      a_x     <= up.x;
      a_t_cur <= up.t_cur;
      a_t_old <= up.t_old;
      a_sum   <= up.sum;
      a_last  <= up.last;
      a_pt    <= up.x * up.t_cur;
      a_pc    <= coef * up.t_cur;
    end
  end

  // 2*x*T rounded half up at Q2.30 equals x*T rounded half up at a 29-bit shift
  always_comb begin
    pt_round = (a_pt + HALF_SH29) >>> 29;
    pc_round = (a_pc + HALF_SH30) >>> 30;
    diff     = $signed(pt_round[DIFF_W-1:0]) - DIFF_W'(a_t_old);
    if (diff > DIFF_W'(ONE_Q30)) begin
      t_next = ONE_Q30;
    end else if (diff < DIFF_W'(NEG_ONE_Q30)) begin
      t_next = NEG_ONE_Q30;
    end else begin
      t_next = diff[T_W-1:0];
    end
    term     = $signed(pc_round[SUM_W-1:0]);
    sum_next = active ? (a_sum + term) : a_sum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_ready) begin
      b_valid <= a_valid;
    end
    if (b_ready && a_valid) begin
      b_x     <= a_x;
      b_t_cur <= t_next;
      b_t_old <= a_t_cur;
      b_sum   <= sum_next;
      b_last  <= a_last;
    end
  end

  assign dn = '{valid: b_valid, x: b_x, t_cur: b_t_cur, t_old: b_t_old,
                sum: b_sum, last: b_last};

  `CSE_ASSERT_IMPL(t_range_a, clk, rst, b_valid, (b_t_cur <= ONE_Q30) && (b_t_cur >= NEG_ONE_Q30), "polynomial value left [-1,1]")
  `CSE_ASSERT_NEXT(b_hold_a, clk, rst, b_valid && !dn_ready, b_valid && $stable(b_sum), "stalled cell output changed")
  `CSE_ASSERT_NEXT(a_drain_a, clk, rst, a_valid && b_ready, b_valid, "multiply stage lost an item")

endmodule

`default_nettype wire

@@ rtl/chebyshev_series_evaluator.sv @@
// Chebyshev series evaluator: series_value = 1 + sum c_k*T_k(x), k = 1..series_order.
// Input channel: sample_valid / sample_stall carry sample (x_value in Q2.30, clamped
//   to [-1,1], and last_sample). A transfer happens at an edge with valid high and
//   stall low.
// Output channel: result_valid / result_stall carry result (series_value in Q24.24
//   and last_result, a copy of last_sample). One result per sample, in order.
// Configuration: cfg_we, cfg_index, cfg_data. Index 0 is series_order (cfg_data[2:0];
//   above MAX_ORDER acts as MAX_ORDER), index k is coef_k in Q8.24. Write only while idle.
// Structure: a row of MAX_ORDER cells, cell k adding the T_k term and handing
//   T_(k+1), T_k and the partial sum to its neighbor; each cell has a multiply
//   stage and a round/add stage, then one output register.
// Pipeline: a sample loads the first cell's multiply stage at its transfer edge,
//   then passes through two stages per cell and finally the output register.
// Throughput: one sample per cycle, sustained while result_stall stays low.
// Stall: a stalled result holds in the output register; items behind it keep
//   advancing into empty stages, and the input stalls only once the row is full.
// Reset: clears all valid bits, series_order and the coefficients (order zero,
//   so every result is 1.0 until configured).
`default_nettype none
`include "chebyshev_series_evaluator_defines.svh"

module chebyshev_series_evaluator import cse_pkg::*; #(
  parameter int MAX_ORDER = 7
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  sample_valid,
  output logic                  sample_stall,
  input  sample_t               sample,
  output logic                  result_valid,
  input  logic                  result_stall,
  output result_t               result,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [ORDER_W-1:0]       series_order;
  logic signed [COEF_W-1:0] coef [MAX_ORDER];
  logic [MAX_ORDER-1:0]     active;

  cell_bus_t              bus [MAX_ORDER+1];
  logic [MAX_ORDER:0]     ready;
  logic signed [T_W-1:0]  x_clamp;
  logic                   out_ready;

  // Configuration writes; indexes past MAX_ORDER are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      series_order <= '0;
      for (int j = 0; j < MAX_ORDER; j++) begin
        coef[j] <= '0;
      end
    end else if (cfg_we) begin
      if (cfg_index == REG_SERIES_ORDER) begin
        series_order <= cfg_data[ORDER_W-1:0];
      end
      for (int j = 0; j < MAX_ORDER; j++) begin
        if (cfg_index == CFG_IDX_W'(j + int'(REG_COEF_1))) begin
          coef[j] <= $signed(cfg_data);
        end
      end
    end
  end

  // Clamp the sample to [-1,1]
  always_comb begin
    if (sample.x_value > ONE_Q30) begin
      x_clamp = ONE_Q30;
    end else if (sample.x_value < NEG_ONE_Q30) begin
      x_clamp = NEG_ONE_Q30;
    end else begin
      x_clamp = sample.x_value;
    end
  end

  // Seed the row with T1 = x, T0 = 1 and the fixed 1.0 term
  assign bus[0] = '{valid: sample_valid, x: x_clamp, t_cur: x_clamp, t_old: ONE_Q30,
                    sum: ONE_Q24, last: sample.last_sample};
  assign sample_stall = !ready[0];

  for (genvar j = 0; j < MAX_ORDER; j++) begin : g_cell
    // Cell j carries T_(j+1); enable its term up to the configured order
    assign active[j] = (series_order >= ORDER_W'(j + 1));

    cse_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .up       (bus[j]),
      .up_ready (ready[j]),
      .coef     (coef[j]),
      .active   (active[j]),
      .dn       (bus[j+1]),
      .dn_ready (ready[j+1])
    );
  end

  // Output register; accept from the last cell whenever empty or being drained
  assign out_ready        = !result_valid || !result_stall;
  assign ready[MAX_ORDER] = out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_ready) begin
      result_valid <= bus[MAX_ORDER].valid;
    end
    if (out_ready && bus[MAX_ORDER].valid) begin
      // The 36-bit sum never reaches the 48-bit limits: sign extension is exact
      result.series_value <= OUT_W'(bus[MAX_ORDER].sum);
      result.last_result  <= bus[MAX_ORDER].last;
    end
  end

  `CSE_ASSERT_IMPL(no_sat_a, clk, rst, result_valid, (&result.series_value[OUT_W-1:SUM_W-1]) || !(|result.series_value[OUT_W-1:SUM_W-1]), "series value outside sum range")
  `CSE_ASSERT_IMPL(stall_full_a, clk, rst, sample_stall, result_valid, "input stalled with empty output register")
  `CSE_ASSERT_NEXT(drain_a, clk, rst, result_valid && !result_stall && !bus[MAX_ORDER].valid, !result_valid, "result repeated after transfer")

endmodule

`default_nettype wire
